// ===== rtl/fctsb_pkg.sv =====
// Package for the FM timer/status block: action codes, port codes, register
// numbers, sequencer state type. No dependencies.
package fctsb_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] PORT_INDEX0 = 2'd0;
    localparam logic [1:0] PORT_DATA0  = 2'd1;
    localparam logic [1:0] PORT_INDEX1 = 2'd2;
    localparam logic [1:0] PORT_DATA1  = 2'd3;

    localparam logic [7:0] REG_T1_PRESET = 8'h02;
    localparam logic [7:0] REG_T2_PRESET = 8'h03;
    localparam logic [7:0] REG_CONTROL   = 8'h04;

    localparam logic [7:0] READ_IDLE_BYTE = 8'hFF;

    localparam int CNT_W = 11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RED1,
        ST_RED2,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/fm_chip_timer_status_block_unit.sv =====
// Top level of the FM timer/status block: index/data ports, two preset timers,
// status flags. Depends on fctsb_pkg.
//
// Usage:
//   Input stream (s_*): one word per bus access or 80 us tick. tuser carries
//   action and port, tdata the write byte. Output stream (m_*): one word per
//   input word, read byte in tdata and the IRQ status bit in tuser.
//   Config channel (cfg_*): extended_mode bit, always ready; write only while
//   the block is idle.
//   A tick checks each running timer in turn on one shared subtractor,
//   which subtracts the timer's period from its incremented count while
//   the remainder is at least the period; any such subtraction is an
//   overflow and may raise the timer's status flags.
//   s_tready is high only while the sequencer is idle, so a new word is
//   taken only after the previous one has reached the output register.
//   If the receiver stalls, the finished word waits in the output register;
//   one more word may be accepted and computed, then the block holds.
//   Reset clears all registers, flags and counters to zero.
module fm_chip_timer_status_block_unit
    import fctsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,      // extended_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] data
    input  logic [3:0] s_tuser,       // [1:0] action, [3:2] port
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] read_data
    output logic       m_tuser        // [0] irq_pending
);

    state_t           state_reg, state_next;
    logic             ext_reg, ext_next;
    logic [7:0]       b0_idx_reg, b0_idx_next;
    logic [7:0]       b1_idx_reg, b1_idx_next;
    logic [7:0]       t1_pre_reg, t1_pre_next;
    logic [7:0]       t2_pre_reg, t2_pre_next;
    logic [7:0]       ctrl_reg, ctrl_next;
    logic [7:0]       t1_cnt_reg, t1_cnt_next;
    logic [9:0]       t2_cnt_reg, t2_cnt_next;
    logic [2:0]       flags_reg, flags_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] per_reg, per_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       rd_reg, rd_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic             m_irq_reg, m_irq_next;

    logic [1:0]       in_action;
    logic [1:0]       in_port;
    logic [7:0]       wr_num;
    logic             wr_blocked;
    logic [CNT_W-1:0] diff;
    logic             ge;
    logic [CNT_W-1:0] t1_load;
    logic [CNT_W-1:0] t1_period;
    logic [CNT_W-1:0] t2_load;
    logic [CNT_W-1:0] t2_period;

    assign in_action = s_tuser[1:0];
    assign in_port   = s_tuser[3:2];
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_irq_reg;

    assign wr_num     = in_port[1] ? b1_idx_reg : b0_idx_reg;
    assign wr_blocked = in_port[1] & ext_reg;

    // shared subtract/compare unit
    assign diff = rem_reg - per_reg;
    assign ge   = (rem_reg >= per_reg);

    assign t1_load   = {3'b000, t1_cnt_reg} + CNT_W'(1);
    assign t1_period = CNT_W'(9'd256 - {1'b0, t1_pre_reg});
    assign t2_load   = {1'b0, t2_cnt_reg} + CNT_W'(1);
    assign t2_period = {t2_pre_reg == 8'd0 ? 1'b1 : 1'b0, 8'(~t2_pre_reg + 8'd1), 2'b00};

    always_comb
    begin
        state_next   = state_reg;
        ext_next     = ext_reg;
        b0_idx_next  = b0_idx_reg;
        b1_idx_next  = b1_idx_reg;
        t1_pre_next  = t1_pre_reg;
        t2_pre_next  = t2_pre_reg;
        ctrl_next    = ctrl_reg;
        t1_cnt_next  = t1_cnt_reg;
        t2_cnt_next  = t2_cnt_reg;
        flags_next   = flags_reg;
        rem_next     = rem_reg;
        per_next     = per_reg;
        ovf_next     = ovf_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_irq_next   = m_irq_reg;

        if (cfg_valid)
        begin
            ext_next = cfg_data;
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rd_next    = 8'h00;
                    ovf_next   = 1'b0;
                    state_next = ST_DONE;
                    unique case (in_action)
                        ACT_WRITE:
                        begin
                            unique case (in_port)
                                PORT_INDEX0: b0_idx_next = s_tdata;
                                PORT_INDEX1: b1_idx_next = s_tdata;
                                default:
                                begin
                                    if (wr_num == REG_T1_PRESET)
                                    begin
                                        t1_pre_next = s_tdata;
                                    end
                                    else if (wr_num == REG_T2_PRESET)
                                    begin
                                        t2_pre_next = s_tdata;
                                    end
                                    else if (wr_num == REG_CONTROL && !wr_blocked)
                                    begin
                                        ctrl_next = s_tdata;
                                        if (s_tdata[7])
                                        begin
                                            flags_next = 3'b000;
                                        end
                                        else
                                        begin
                                            if (s_tdata[6]) flags_next[1] = 1'b0;
                                            if (s_tdata[5]) flags_next[0] = 1'b0;
                                            if (s_tdata[0]) t1_cnt_next = 8'd0;
                                            if (s_tdata[1]) t2_cnt_next = 10'd0;
                                        end
                                    end
                                end
                            endcase
                        end
                        ACT_READ:
                        begin
                            rd_next = in_port[0] ? READ_IDLE_BYTE : {flags_reg, 5'b00000};
                        end
                        ACT_TICK:
                        begin
                            if (ctrl_reg[0])
                            begin
                                rem_next   = t1_load;
                                per_next   = t1_period;
                                state_next = ST_RED1;
                            end
                            else if (ctrl_reg[1])
                            begin
                                rem_next   = t2_load;
                                per_next   = t2_period;
                                state_next = ST_RED2;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RED1:
            begin
                if (ge)
                begin
                    rem_next = diff;
                    ovf_next = 1'b1;
                end
                else
                begin
                    t1_cnt_next = rem_reg[7:0];
                    if (ovf_reg && !ctrl_reg[6])
                    begin
                        flags_next = flags_reg | 3'b110;
                    end
                    ovf_next = 1'b0;
                    if (ctrl_reg[1])
                    begin
                        rem_next   = t2_load;
                        per_next   = t2_period;
                        state_next = ST_RED2;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RED2:
            begin
                if (ge)
                begin
                    rem_next = diff;
                    ovf_next = 1'b1;
                end
                else
                begin
                    t2_cnt_next = rem_reg[9:0];
                    if (ovf_reg && !ctrl_reg[5])
                    begin
                        flags_next = flags_reg | 3'b101;
                    end
                    ovf_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_reg;
                    m_irq_next   = flags_reg[2];
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ext_reg     <= 1'b0;
            b0_idx_reg  <= 8'd0;
            b1_idx_reg  <= 8'd0;
            t1_pre_reg  <= 8'd0;
            t2_pre_reg  <= 8'd0;
            ctrl_reg    <= 8'd0;
            t1_cnt_reg  <= 8'd0;
            t2_cnt_reg  <= 10'd0;
            flags_reg   <= 3'd0;
            rem_reg     <= '0;
            per_reg     <= '0;
            ovf_reg     <= 1'b0;
            rd_reg      <= 8'd0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= 8'd0;
            m_irq_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ext_reg     <= ext_next;
            b0_idx_reg  <= b0_idx_next;
            b1_idx_reg  <= b1_idx_next;
            t1_pre_reg  <= t1_pre_next;
            t2_pre_reg  <= t2_pre_next;
            ctrl_reg    <= ctrl_next;
            t1_cnt_reg  <= t1_cnt_next;
            t2_cnt_reg  <= t2_cnt_next;
            flags_reg   <= flags_next;
            rem_reg     <= rem_next;
            per_reg     <= per_next;
            ovf_reg     <= ovf_next;
            rd_reg      <= rd_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_irq_reg   <= m_irq_next;
        end
    end

endmodule
